### design/length_prefixed_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Deframer check failed in the same cycle.");

// Next-cycle implication, disabled while reset is asserted.
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Deframer check failed one cycle later.");

`endif

### design/lpfd_pkg.sv
// Types and constants of the length-prefixed frame deframer.
// Depends on nothing; used by every deframer module.
package lpfd_pkg;

    localparam logic [7:0] RESET_MAGIC = 8'h81;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TYPE    = 3'd2,
        PH_CHECK   = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_NO_HEADER = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       has_data;
        logic [7:0] payload_byte;
        logic       frame_end;
        t_status    frame_status;
        logic [7:0] frame_type;
        logic [7:0] payload_length;
    } t_out_item;

endpackage

### design/lpfd_core.sv
// Frame state registers and the per-byte deframing logic.
// Depends on lpfd_pkg and the assertion macro header.
`include "length_prefixed_frame_deframer_top_macros.svh"

module lpfd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_accept,
    input  lpfd_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output lpfd_pkg::t_out_item o_res
);
    import lpfd_pkg::*;

    logic [7:0] r_magic;
    t_phase     r_phase,  n_phase;
    logic       r_matched, n_matched;
    logic [7:0] r_rem,    n_rem;
    logic [7:0] r_sum,    n_sum;
    logic [7:0] r_exp,    n_exp;
    logic [7:0] r_type,   n_type;
    logic [7:0] r_len,    n_len;

    logic [7:0] b;
    logic       tmo;
    logic [7:0] rem_dec;
    logic       rem_last;
    logic [7:0] sum_add;
    logic       res_end;
    logic       res_data;
    logic       idle_tmo;

    assign b        = i_item.rx_byte;
    assign tmo      = i_item.req_type;
    assign rem_dec  = r_rem - 8'd1;
    assign rem_last = (r_rem == 8'd1);
    assign sum_add  = r_sum + b;

    always_comb begin
        n_phase   = r_phase;
        n_matched = r_matched;
        n_rem     = r_rem;
        n_sum     = r_sum;
        n_exp     = r_exp;
        n_type    = r_type;
        n_len     = r_len;
        if (i_accept) begin
            if (tmo) begin
                n_phase   = PH_MAGIC;
                n_matched = 1'b0;
                n_rem     = 8'd0;
                n_sum     = 8'd0;
                n_exp     = 8'd0;
                n_type    = 8'd0;
                n_len     = 8'd0;
            end else begin
                unique case (r_phase)
                    PH_LENGTH: begin
                        if (!r_matched || b == 8'd0) begin
                            n_phase   = PH_MAGIC;
                            n_matched = 1'b0;
                            n_len     = 8'd0;
                        end else begin
                            n_phase = PH_TYPE;
                            n_len   = b;
                            n_rem   = b;
                        end
                    end
                    PH_TYPE: begin
                        if (rem_last) begin
                            n_phase   = PH_MAGIC;
                            n_matched = 1'b0;
                            n_rem     = 8'd0;
                            n_len     = 8'd0;
                        end else begin
                            n_phase = PH_CHECK;
                            n_type  = b;
                            n_rem   = rem_dec;
                        end
                    end
                    PH_CHECK: begin
                        if (rem_last) begin
                            n_phase   = PH_MAGIC;
                            n_matched = 1'b0;
                            n_rem     = 8'd0;
                            n_type    = 8'd0;
                            n_len     = 8'd0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_exp   = b;
                            n_rem   = rem_dec;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (rem_last) begin
                            n_phase   = PH_MAGIC;
                            n_matched = 1'b0;
                            n_rem     = 8'd0;
                            n_sum     = 8'd0;
                            n_exp     = 8'd0;
                            n_type    = 8'd0;
                            n_len     = 8'd0;
                        end else begin
                            n_sum = sum_add;
                            n_rem = rem_dec;
                        end
                    end
                    default: begin
                        n_phase   = PH_LENGTH;
                        n_matched = (b == r_magic);
                        n_rem     = 8'd0;
                        n_sum     = 8'd0;
                        n_exp     = 8'd0;
                        n_type    = 8'd0;
                        n_len     = 8'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (tmo) begin
            if (r_phase != PH_MAGIC) begin
                o_res_valid        = i_accept;
                o_res.frame_end    = 1'b1;
                o_res.frame_status = ST_TRUNCATED;
                if (r_phase == PH_CHECK || r_phase == PH_PAYLOAD) begin
                    o_res.frame_type = r_type;
                end
                if (r_phase == PH_PAYLOAD) begin
                    o_res.payload_length = r_len - 8'd2 - r_rem;
                end
            end
        end else begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (!r_matched) begin
                        o_res_valid        = i_accept;
                        o_res.frame_end    = 1'b1;
                        o_res.frame_status = ST_BAD_MAGIC;
                    end else if (b == 8'd0) begin
                        o_res_valid        = i_accept;
                        o_res.frame_end    = 1'b1;
                        o_res.frame_status = ST_NO_HEADER;
                    end
                end
                PH_TYPE: begin
                    if (rem_last) begin
                        o_res_valid        = i_accept;
                        o_res.frame_end    = 1'b1;
                        o_res.frame_status = ST_NO_HEADER;
                        o_res.frame_type   = b;
                    end
                end
                PH_CHECK: begin
                    if (rem_last) begin
                        o_res_valid        = i_accept;
                        o_res.frame_end    = 1'b1;
                        o_res.frame_status = (r_sum == b) ? ST_OK : ST_BAD_SUM;
                        o_res.frame_type   = r_type;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid        = i_accept;
                    o_res.has_data     = 1'b1;
                    o_res.payload_byte = b;
                    if (rem_last) begin
                        o_res.frame_end      = 1'b1;
                        o_res.frame_status   = (sum_add == r_exp) ? ST_OK : ST_BAD_SUM;
                        o_res.frame_type     = r_type;
                        o_res.payload_length = r_len - 8'd2;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= RESET_MAGIC;
            r_phase   <= PH_MAGIC;
            r_matched <= 1'b0;
            r_rem     <= 8'd0;
            r_sum     <= 8'd0;
            r_exp     <= 8'd0;
            r_type    <= 8'd0;
            r_len     <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_magic <= i_cfg_wr_data;
            end
            r_phase   <= n_phase;
            r_matched <= n_matched;
            r_rem     <= n_rem;
            r_sum     <= n_sum;
            r_exp     <= n_exp;
            r_type    <= n_type;
            r_len     <= n_len;
        end
    end

    assign res_end  = o_res_valid && o_res.frame_end;
    assign res_data = o_res_valid && o_res.has_data;
    assign idle_tmo = i_accept && tmo && (r_phase == PH_MAGIC);

    `LPFD_ASSERT_NEXT(a_end_returns_idle, i_clk, i_rst_n, res_end, r_phase == PH_MAGIC)
    `LPFD_ASSERT_NOW(a_data_only_in_payload, i_clk, i_rst_n, res_data, r_phase == PH_PAYLOAD)
    `LPFD_ASSERT_NOW(a_idle_timeout_silent, i_clk, i_rst_n, idle_tmo, !o_res_valid)

endmodule

### design/lpfd_obuf.sv
// Two-entry result buffer between the deframing logic and the output channel.
// Depends on lpfd_pkg and the assertion macro header.
`include "length_prefixed_frame_deframer_top_macros.svh"

module lpfd_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lpfd_pkg::t_out_item i_push_item,
    output logic                o_has_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lpfd_pkg::t_out_item o_out_data
);
    import lpfd_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_has_room  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    `LPFD_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `LPFD_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, o_has_room)

endmodule

### design/length_prefixed_frame_deframer_top.sv
// Latency: a result is offered on the output channel in the cycle after its input transfer
// when the result buffer holds nothing older.
// Throughput: one input transfer per cycle while the output side keeps up.
// The two-entry result buffer sets the figure; with it full, input waits until a result leaves.
// Reset is synchronous and active low; it sets the magic byte to 0x81 and
// returns the deframer to waiting for a magic byte with an empty buffer.
module length_prefixed_frame_deframer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpfd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lpfd_pkg::t_out_item o_out_data
);
    import lpfd_pkg::*;

    logic      accept;
    logic      res_valid;
    t_out_item res;
    logic      has_room;

    assign o_in_ready = has_room;
    assign accept     = i_in_valid && has_room;

    lpfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (i_in_data),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    lpfd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_item (res),
        .o_has_room  (has_room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### verif/lpfd_scoreboard_pkg.sv
// Scoreboard for the length-prefixed frame deframer: predicts results per input transfer.
// Depends on lpfd_pkg for the payload structs, phases and status codes.
package lpfd_scoreboard_pkg;

    import lpfd_pkg::*;

    class deframer_scoreboard;

        logic [7:0] magic;
        t_phase     phase;
        bit         magic_ok;
        logic [7:0] remaining;
        logic [7:0] sum_so_far;
        logic [7:0] sum_field;
        logic [7:0] type_hold;
        logic [7:0] length_hold;
        t_out_item  due_results[$];
        int         errors;
        int         results_seen;
        int         frames_closed;
        int         bad_frames;

        function new();
            magic = RESET_MAGIC;
            clear_frame();
        endfunction

        function void clear_frame();
            phase       = PH_MAGIC;
            magic_ok    = 1'b0;
            remaining   = 8'h00;
            sum_so_far  = 8'h00;
            sum_field   = 8'h00;
            type_hold   = 8'h00;
            length_hold = 8'h00;
        endfunction

        function void set_magic(logic [7:0] value);
            magic = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void post_result(bit data, logic [7:0] byte_val, bit fend, t_status st,
                                  logic [7:0] ftype, logic [7:0] plen);
            t_out_item r;
            r                = '0;
            r.has_data       = data;
            r.payload_byte   = data ? byte_val : 8'h00;
            r.frame_end      = fend;
            r.frame_status   = fend ? st : ST_OK;
            r.frame_type     = fend ? ftype : 8'h00;
            r.payload_length = fend ? plen : 8'h00;
            due_results.push_back(r);
        endfunction

        // Returns 0 when the transfer is a timeout that the idle deframer ignores.
        function bit take_transfer(t_in_item it);
            logic [7:0] b;
            t_status    st;
            b = it.rx_byte;
            if (it.req_type) begin
                if (phase == PH_MAGIC) return 1'b0;
                post_result(1'b0, 8'h00, 1'b1, ST_TRUNCATED,
                            (phase == PH_CHECK || phase == PH_PAYLOAD) ? type_hold : 8'h00,
                            (phase == PH_PAYLOAD) ? length_hold - 8'd2 - remaining : 8'h00);
                clear_frame();
                return 1'b1;
            end
            case (phase)
                PH_MAGIC: begin
                    clear_frame();
                    magic_ok = (b == magic);
                    phase    = PH_LENGTH;
                end
                PH_LENGTH: begin
                    length_hold = b;
                    if (!magic_ok) begin
                        post_result(1'b0, 8'h00, 1'b1, ST_BAD_MAGIC, 8'h00, 8'h00);
                        clear_frame();
                    end else if (b == 8'h00) begin
                        post_result(1'b0, 8'h00, 1'b1, ST_NO_HEADER, 8'h00, 8'h00);
                        clear_frame();
                    end else begin
                        remaining = b;
                        phase     = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    type_hold = b;
                    remaining = remaining - 8'd1;
                    if (remaining == 8'h00) begin
                        post_result(1'b0, 8'h00, 1'b1, ST_NO_HEADER, type_hold, 8'h00);
                        clear_frame();
                    end else begin
                        phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    sum_field = b;
                    remaining = remaining - 8'd1;
                    if (remaining == 8'h00) begin
                        st = (sum_so_far == sum_field) ? ST_OK : ST_BAD_SUM;
                        post_result(1'b0, 8'h00, 1'b1, st, type_hold, 8'h00);
                        clear_frame();
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
                default: begin
                    sum_so_far = sum_so_far + b;
                    remaining  = remaining - 8'd1;
                    if (remaining == 8'h00) begin
                        st = (sum_so_far == sum_field) ? ST_OK : ST_BAD_SUM;
                        post_result(1'b1, b, 1'b1, st, type_hold, length_hold - 8'd2);
                        clear_frame();
                    end else begin
                        post_result(1'b1, b, 1'b0, ST_OK, 8'h00, 8'h00);
                    end
                end
            endcase
            return 1'b1;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (due_results.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            want = due_results.pop_front();
            compare_field("has_data", 8'(got.has_data), 8'(want.has_data));
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
            compare_field("frame_status", 8'(got.frame_status), 8'(want.frame_status));
            compare_field("frame_type", got.frame_type, want.frame_type);
            compare_field("payload_length", got.payload_length, want.payload_length);
            if (want.frame_end) begin
                frames_closed++;
                if (want.frame_status != ST_OK) bad_frames++;
            end
        endtask

        task flush_leftovers();
            if (due_results.size() != 0) begin
                report($sformatf("%0d expected results never arrived", due_results.size()));
                due_results.delete();
            end
        endtask

    endclass

endpackage

### verif/tb_top.sv
// Top-level deframer testbench: directed frames, then random frames under several magic
// settings, random stalls save in the last. Depends on lpfd_pkg and lpfd_scoreboard_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;
    import lpfd_scoreboard_pkg::*;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;

    deframer_scoreboard sb = new();
    bit         gaps_on = 1'b1;
    int         transfers_sent = 0;
    logic [7:0] cur_magic = RESET_MAGIC;

    length_prefixed_frame_deframer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[length_prefixed_frame_deframer_top] ERROR");
        $finish;
    end

    initial begin
        forever begin
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    task automatic push_item(bit is_timeout, logic [7:0] b);
        t_in_item it;
        it.req_type = is_timeout;
        it.rx_byte  = b;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.take_transfer(it)) transfers_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(logic [7:0] bytes[$]);
        foreach (bytes[i]) push_item(1'b0, bytes[i]);
    endtask

    task automatic send_timeout();
        push_item(1'b1, 8'($urandom));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        i_in_valid = 1'b0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        sb.flush_leftovers();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_magic(logic [7:0] value);
        drain();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.set_magic(value);
        cur_magic = value;
    endtask

    task automatic send_random_frame();
        int         pick;
        int         len;
        int         cut;
        logic [7:0] body[$];
        logic [7:0] sum;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(2, 12);
            body = {cur_magic, 8'(len), 8'($urandom), 8'h00};
            sum  = 8'h00;
            for (int i = 0; i < len - 2; i++) begin
                body.push_back(8'($urandom));
                sum += body[$];
            end
            body[3] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sum;
            if (pick >= 58) begin
                cut  = $urandom_range(1, body.size() - 1);
                body = body[0:cut-1];
                send_bytes(body);
                send_timeout();
            end else begin
                send_bytes(body);
            end
        end else if (pick < 78) begin
            if ($urandom_range(0, 1) == 0) send_bytes({cur_magic, 8'h00});
            else send_bytes({cur_magic, 8'h01, 8'($urandom)});
        end else if (pick < 88) begin
            send_bytes({cur_magic ^ 8'($urandom_range(1, 255)), 8'($urandom)});
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 2) == 0) send_timeout();
                else push_item(1'b0, 8'($urandom));
            end
            if ($urandom_range(0, 9) < 7) send_timeout();
        end
    endtask

    initial begin
        logic [7:0] magics[5];
        int         target;
        bit         paused;
        magics = '{RESET_MAGIC, 8'h00, 8'hFF, 8'($urandom_range(1, 254)), RESET_MAGIC};
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_timeout();
        send_bytes({RESET_MAGIC, 8'h00});
        send_bytes({8'h55, 8'h05});
        send_bytes({RESET_MAGIC, 8'h01, 8'hAB});
        send_bytes({RESET_MAGIC, 8'h02, 8'h7E, 8'h00});
        send_bytes({RESET_MAGIC, 8'h04, 8'hC3, 8'hFE, 8'hFF, 8'hFF});
        send_bytes({8'h00});
        send_timeout();
        send_bytes({RESET_MAGIC, 8'h05, 8'h11, 8'h00, 8'h22});
        send_timeout();

        for (int p = 0; p < 5; p++) begin
            if (p > 0) write_magic(magics[p]);
            if (p == 4) gaps_on = 1'b0;
            target = transfers_sent + 220;
            while (transfers_sent < target) begin
                send_random_frame();
                if (p == 1 && !paused && transfers_sent > target - 110) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d effective transfers over five magic settings; checked %0d results,",
                 transfers_sent, sb.results_seen);
        $display("closing %0d frames, %0d of them with an error status.",
                 sb.frames_closed, sb.bad_frames);
        if (sb.errors == 0) begin
            $display("[length_prefixed_frame_deframer_top] OK");
        end else begin
            $display("[length_prefixed_frame_deframer_top] ERROR");
        end
        $finish;
    end

endmodule
